### hdl/nfba_pkg.sv
// Package for the next-fit block allocator: shared constants, codes, state and
// micro-operation enums, and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package nfba_pkg;

    // Defaults for the top-level parameters (HEAP_UNITS and UNIT_BYTES: powers of two)
    localparam int HEAP_UNITS_DEF = 4096;
    localparam int UNIT_BYTES_DEF = 16;

    // Fixed field widths
    localparam int ADDR_W  = 12;
    localparam int BYTES_W = 16;
    localparam int GROW_W  = 12;
    localparam int LIMIT_W = 13;
    localparam int CFG_W   = 13;
    localparam int UNITS_W = 17;
    localparam int CMP_W   = 18;

    // Configuration reset values
    localparam logic [GROW_W-1:0]  GROW_MIN_RST    = 12'd1024;
    localparam logic [LIMIT_W-1:0] ARENA_LIMIT_RST = 13'd4096;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_GROW_MIN    = 1'b0;
    localparam logic CFG_ARENA_LIMIT = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_A_ROOT,
        S_A_LINK,
        S_A_FETCH,
        S_A_CHECK,
        S_A_CARVE2,
        S_A_REGROW,
        S_A_RELINK,
        S_I_FETCH,
        S_I_CHECK,
        S_I_RDNX,
        S_I_HI,
        S_I_LO,
        S_RESP
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_START,
        DP_A_ROOT,
        DP_A_LINK,
        DP_A_FETCH,
        DP_A_TAKE,
        DP_A_CARVE,
        DP_A_CARVE2,
        DP_A_NEXT,
        DP_GROW,
        DP_A_REGROW,
        DP_A_RELINK,
        DP_I_FETCH,
        DP_I_FOUND,
        DP_I_NEXT,
        DP_I_RDNX,
        DP_I_HI,
        DP_I_LO,
        DP_FAIL,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic op_free;
        logic bad_free;
        logic fit;
        logic exact;
        logic at_rover;
        logic grow_ok;
        logic walk_end;
        logic found;
        logic iwalk_end;
    } dp_stat_t;

endpackage

### hdl/nfba_ctrl.sv
// Controller of the next-fit block allocator: sequences list walks, growth,
// insertion and the result handshake. Depends on nfba_pkg.
`timescale 1ns / 1ps

module nfba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  nfba_pkg::dp_stat_t st,
    output nfba_pkg::dp_cmd_t  cmd
);

    nfba_pkg::state_t state_reg, state_next;
    logic ins_grow_reg, ins_grow_next;
    logic out_valid_reg, out_valid_next;

    // State and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nfba_pkg::S_IDLE;
            ins_grow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ins_grow_reg  <= ins_grow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath command
    always_comb
    begin
        state_next     = state_reg;
        ins_grow_next  = ins_grow_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = nfba_pkg::DP_NOP;
        unique case (state_reg)
            nfba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = nfba_pkg::DP_LATCH;
                    state_next = nfba_pkg::S_START;
                end
            end
            nfba_pkg::S_START:
            begin
                cmd.op = nfba_pkg::DP_START;
                priority if (!st.op_free)
                    state_next = nfba_pkg::S_A_ROOT;
                else if (st.bad_free)
                    state_next = nfba_pkg::S_RESP;
                else
                begin
                    ins_grow_next = 1'b0;
                    state_next    = nfba_pkg::S_I_FETCH;
                end
            end
            nfba_pkg::S_A_ROOT:
            begin
                cmd.op     = nfba_pkg::DP_A_ROOT;
                state_next = nfba_pkg::S_A_LINK;
            end
            nfba_pkg::S_A_LINK:
            begin
                cmd.op     = nfba_pkg::DP_A_LINK;
                state_next = nfba_pkg::S_A_FETCH;
            end
            nfba_pkg::S_A_FETCH:
            begin
                cmd.op     = nfba_pkg::DP_A_FETCH;
                state_next = nfba_pkg::S_A_CHECK;
            end
            nfba_pkg::S_A_CHECK:
            begin
                priority if (st.fit && st.exact)
                begin
                    cmd.op     = nfba_pkg::DP_A_TAKE;
                    state_next = nfba_pkg::S_RESP;
                end
                else if (st.fit)
                begin
                    cmd.op     = nfba_pkg::DP_A_CARVE;
                    state_next = nfba_pkg::S_A_CARVE2;
                end
                else if (st.at_rover && st.grow_ok)
                begin
                    cmd.op        = nfba_pkg::DP_GROW;
                    ins_grow_next = 1'b1;
                    state_next    = nfba_pkg::S_I_FETCH;
                end
                else if (st.at_rover || st.walk_end)
                begin
                    cmd.op     = nfba_pkg::DP_FAIL;
                    state_next = nfba_pkg::S_RESP;
                end
                else
                begin
                    cmd.op     = nfba_pkg::DP_A_NEXT;
                    state_next = nfba_pkg::S_A_FETCH;
                end
            end
            nfba_pkg::S_A_CARVE2:
            begin
                cmd.op     = nfba_pkg::DP_A_CARVE2;
                state_next = nfba_pkg::S_RESP;
            end
            nfba_pkg::S_A_REGROW:
            begin
                cmd.op     = nfba_pkg::DP_A_REGROW;
                state_next = nfba_pkg::S_A_RELINK;
            end
            nfba_pkg::S_A_RELINK:
            begin
                if (st.walk_end)
                begin
                    cmd.op     = nfba_pkg::DP_FAIL;
                    state_next = nfba_pkg::S_RESP;
                end
                else
                begin
                    cmd.op     = nfba_pkg::DP_A_RELINK;
                    state_next = nfba_pkg::S_A_FETCH;
                end
            end
            nfba_pkg::S_I_FETCH:
            begin
                cmd.op     = nfba_pkg::DP_I_FETCH;
                state_next = nfba_pkg::S_I_CHECK;
            end
            nfba_pkg::S_I_CHECK:
            begin
                priority if (st.found)
                begin
                    cmd.op     = nfba_pkg::DP_I_FOUND;
                    state_next = nfba_pkg::S_I_RDNX;
                end
                else if (st.iwalk_end)
                begin
                    cmd.op     = nfba_pkg::DP_FAIL;
                    state_next = nfba_pkg::S_RESP;
                end
                else
                begin
                    cmd.op     = nfba_pkg::DP_I_NEXT;
                    state_next = nfba_pkg::S_I_FETCH;
                end
            end
            nfba_pkg::S_I_RDNX:
            begin
                cmd.op     = nfba_pkg::DP_I_RDNX;
                state_next = nfba_pkg::S_I_HI;
            end
            nfba_pkg::S_I_HI:
            begin
                cmd.op     = nfba_pkg::DP_I_HI;
                state_next = nfba_pkg::S_I_LO;
            end
            nfba_pkg::S_I_LO:
            begin
                cmd.op     = nfba_pkg::DP_I_LO;
                state_next = ins_grow_reg ? nfba_pkg::S_A_REGROW : nfba_pkg::S_RESP;
            end
            nfba_pkg::S_RESP:
            begin
                // Hand over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = nfba_pkg::DP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = nfba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nfba_pkg::S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == nfba_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### hdl/nfba_dp.sv
// Datapath of the next-fit block allocator: link and size memories, walk
// registers, allocator state, configuration and result registers. Depends on nfba_pkg.
`timescale 1ns / 1ps

module nfba_dp #(
    parameter int HEAP_UNITS = nfba_pkg::HEAP_UNITS_DEF,
    parameter int UNIT_BYTES = nfba_pkg::UNIT_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [nfba_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          op,
    input  logic [nfba_pkg::BYTES_W-1:0]  req_bytes,
    input  logic [nfba_pkg::ADDR_W-1:0]   free_addr,
    output logic                          granted,
    output logic [nfba_pkg::ADDR_W-1:0]   addr,
    input  nfba_pkg::dp_cmd_t             cmd,
    output nfba_pkg::dp_stat_t            st
);

    localparam int IDX_W      = $clog2(HEAP_UNITS);
    localparam int SZ_W       = IDX_W + 1;
    localparam int BP_W       = IDX_W + 1;
    localparam int SUM_W      = IDX_W + 2;
    localparam int WALK_LIMIT = 2 * HEAP_UNITS + 8;
    localparam int STEP_W     = $clog2(WALK_LIMIT + 1);
    localparam int UB_SH      = $clog2(UNIT_BYTES);
    localparam int ADDR_W     = nfba_pkg::ADDR_W;
    localparam int CMP_W      = nfba_pkg::CMP_W;
    localparam int UNITS_W    = nfba_pkg::UNITS_W;
    localparam int BYTES_W    = nfba_pkg::BYTES_W;

    // Free list storage
    logic [IDX_W-1:0] link_mem [HEAP_UNITS];
    logic [SZ_W-1:0]  size_mem [HEAP_UNITS];

    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             we_link, we_size;
    logic [IDX_W-1:0] wr_link;
    logic [SZ_W-1:0]  wr_size;
    logic [IDX_W-1:0] rd_link_q;
    logic [SZ_W-1:0]  rd_size_q;

    // Allocator state and configuration
    logic                          started_reg, started_next;
    logic [IDX_W-1:0]              rover_reg, rover_next;
    logic [BP_W-1:0]               bp_reg, bp_next;
    logic [nfba_pkg::GROW_W-1:0]   grow_min_reg;
    logic [nfba_pkg::LIMIT_W-1:0]  arena_limit_reg;

    // Per-transaction working registers
    logic                 op_reg, op_next;
    logic [UNITS_W-1:0]   units_reg, units_next;
    logic [ADDR_W-1:0]    fa_reg, fa_next;
    logic [IDX_W-1:0]     p_reg, p_next;
    logic [IDX_W-1:0]     prev_reg, prev_next;
    logic [IDX_W-1:0]     q_reg, q_next;
    logic [STEP_W-1:0]    steps_reg, steps_next;
    logic [IDX_W-1:0]     ip_reg, ip_next;
    logic [STEP_W-1:0]    isteps_reg, isteps_next;
    logic [IDX_W-1:0]     ins_bp_reg, ins_bp_next;
    logic [IDX_W-1:0]     nx_reg, nx_next;
    logic [SZ_W-1:0]      szbp_reg, szbp_next;
    logic [SZ_W-1:0]      nsize_reg, nsize_next;
    logic [IDX_W-1:0]     nlink_reg, nlink_next;
    logic                 res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic                 granted_reg, granted_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;

    // Combinational helpers
    logic [BYTES_W:0]     bytes_rnd;
    logic [UNITS_W-1:0]   units_in;
    logic [UNITS_W-1:0]   rd_size_x;
    logic [UNITS_W-1:0]   nu;
    logic [CMP_W-1:0]     lim;
    logic [CMP_W-1:0]     grow_end;
    logic [ADDR_W-1:0]    fa_m1;
    logic [SZ_W-1:0]      carve_size;
    logic [IDX_W-1:0]     carve_q;
    logic                 hi_join, lo_join;

    // Round bytes up to units and add the header unit
    assign bytes_rnd = {1'b0, req_bytes} + (BYTES_W + 1)'(UNIT_BYTES - 1);
    assign units_in  = UNITS_W'(bytes_rnd >> UB_SH) + UNITS_W'(1);

    assign rd_size_x = UNITS_W'(rd_size_q);
    assign nu        = (units_reg > UNITS_W'(grow_min_reg)) ? units_reg
                                                             : UNITS_W'(grow_min_reg);
    assign lim       = (CMP_W'(arena_limit_reg) < CMP_W'(HEAP_UNITS)) ?
                       CMP_W'(arena_limit_reg) : CMP_W'(HEAP_UNITS);
    assign grow_end  = CMP_W'(bp_reg) + CMP_W'(nu);
    assign fa_m1     = fa_reg - ADDR_W'(1);
    assign carve_size = SZ_W'(rd_size_x - units_reg);
    assign carve_q    = IDX_W'(SUM_W'(p_reg) + SUM_W'(carve_size));
    assign hi_join   = (SUM_W'(ins_bp_reg) + SUM_W'(szbp_reg)) == SUM_W'(nx_reg);
    assign lo_join   = (SUM_W'(ip_reg) + SUM_W'(rd_size_q)) == SUM_W'(ins_bp_reg);

    // Status to the controller
    always_comb
    begin
        st.op_free   = (op_reg == nfba_pkg::OP_FREE);
        st.bad_free  = (fa_reg < ADDR_W'(2)) ||
                       (CMP_W'(fa_m1) >= CMP_W'(bp_reg)) ||
                       (CMP_W'(fa_m1) >= CMP_W'(HEAP_UNITS));
        st.fit       = (rd_size_x >= units_reg);
        st.exact     = (rd_size_x == units_reg);
        st.at_rover  = (p_reg == rover_reg);
        st.grow_ok   = (grow_end <= lim);
        st.walk_end  = (steps_reg == STEP_W'(WALK_LIMIT));
        st.found     = ((ins_bp_reg > ip_reg) && (ins_bp_reg < rd_link_q)) ||
                       ((ip_reg >= rd_link_q) &&
                        ((ins_bp_reg > ip_reg) || (ins_bp_reg < rd_link_q)));
        st.iwalk_end = (isteps_reg == STEP_W'(WALK_LIMIT));
    end

    // Micro-operation decode
    always_comb
    begin
        rd_addr       = p_reg;
        wr_addr       = p_reg;
        we_link       = 1'b0;
        we_size       = 1'b0;
        wr_link       = rd_link_q;
        wr_size       = rd_size_q;
        started_next  = started_reg;
        rover_next    = rover_reg;
        bp_next       = bp_reg;
        op_next       = op_reg;
        units_next    = units_reg;
        fa_next       = fa_reg;
        p_next        = p_reg;
        prev_next     = prev_reg;
        q_next        = q_reg;
        steps_next    = steps_reg;
        ip_next       = ip_reg;
        isteps_next   = isteps_reg;
        ins_bp_next   = ins_bp_reg;
        nx_next       = nx_reg;
        szbp_next     = szbp_reg;
        nsize_next    = nsize_reg;
        nlink_next    = nlink_reg;
        res_ok_next   = res_ok_reg;
        res_addr_next = res_addr_reg;
        granted_next  = granted_reg;
        addr_next     = addr_reg;
        unique case (cmd.op)
            nfba_pkg::DP_NOP:
            begin
            end
            nfba_pkg::DP_LATCH:
            begin
                op_next    = op;
                units_next = units_in;
                fa_next    = free_addr;
                steps_next = '0;
            end
            nfba_pkg::DP_START:
            begin
                // First transaction: sentinel becomes a one-block list
                if (!started_reg)
                begin
                    wr_addr      = '0;
                    wr_link      = '0;
                    wr_size      = '0;
                    we_link      = 1'b1;
                    we_size      = 1'b1;
                    rover_next   = '0;
                    started_next = 1'b1;
                end
                ip_next       = started_reg ? rover_reg : '0;
                ins_bp_next   = IDX_W'(fa_m1);
                isteps_next   = '0;
                res_ok_next   = 1'b0;
                res_addr_next = '0;
            end
            nfba_pkg::DP_A_ROOT:
            begin
                prev_next = rover_reg;
                rd_addr   = rover_reg;
            end
            nfba_pkg::DP_A_LINK:
            begin
                p_next = rd_link_q;
            end
            nfba_pkg::DP_A_FETCH:
            begin
                rd_addr = p_reg;
            end
            nfba_pkg::DP_A_TAKE:
            begin
                // Exact fit: unlink the block whole
                wr_addr       = prev_reg;
                wr_link       = rd_link_q;
                we_link       = 1'b1;
                rover_next    = prev_reg;
                res_ok_next   = 1'b1;
                res_addr_next = ADDR_W'(SUM_W'(p_reg) + SUM_W'(1));
            end
            nfba_pkg::DP_A_CARVE:
            begin
                // Shrink the block and hand out its tail
                wr_addr       = p_reg;
                wr_size       = carve_size;
                we_size       = 1'b1;
                q_next        = carve_q;
                rover_next    = prev_reg;
                res_ok_next   = 1'b1;
                res_addr_next = ADDR_W'(SUM_W'(carve_q) + SUM_W'(1));
            end
            nfba_pkg::DP_A_CARVE2:
            begin
                wr_addr = q_reg;
                wr_size = SZ_W'(units_reg);
                we_size = 1'b1;
            end
            nfba_pkg::DP_A_NEXT:
            begin
                prev_next  = p_reg;
                p_next     = rd_link_q;
                steps_next = steps_reg + STEP_W'(1);
            end
            nfba_pkg::DP_GROW:
            begin
                // Extend the arena at the break and free the new block
                wr_addr     = IDX_W'(bp_reg);
                wr_size     = SZ_W'(nu);
                we_size     = 1'b1;
                bp_next     = BP_W'(grow_end);
                ins_bp_next = IDX_W'(bp_reg);
                ip_next     = rover_reg;
                isteps_next = '0;
            end
            nfba_pkg::DP_A_REGROW:
            begin
                prev_next = rover_reg;
                rd_addr   = rover_reg;
            end
            nfba_pkg::DP_A_RELINK:
            begin
                p_next     = rd_link_q;
                steps_next = steps_reg + STEP_W'(1);
            end
            nfba_pkg::DP_I_FETCH:
            begin
                rd_addr = ip_reg;
            end
            nfba_pkg::DP_I_FOUND:
            begin
                nx_next = rd_link_q;
                rd_addr = ins_bp_reg;
            end
            nfba_pkg::DP_I_NEXT:
            begin
                ip_next     = rd_link_q;
                isteps_next = isteps_reg + STEP_W'(1);
            end
            nfba_pkg::DP_I_RDNX:
            begin
                szbp_next = rd_size_q;
                rd_addr   = nx_reg;
            end
            nfba_pkg::DP_I_HI:
            begin
                // Join with the upper neighbor when adjacent
                wr_addr = ins_bp_reg;
                we_link = 1'b1;
                if (hi_join)
                begin
                    wr_size    = SZ_W'(szbp_reg + rd_size_q);
                    wr_link    = rd_link_q;
                    we_size    = 1'b1;
                    nsize_next = SZ_W'(szbp_reg + rd_size_q);
                    nlink_next = rd_link_q;
                end
                else
                begin
                    wr_link    = nx_reg;
                    nsize_next = szbp_reg;
                    nlink_next = nx_reg;
                end
                rd_addr = ip_reg;
            end
            nfba_pkg::DP_I_LO:
            begin
                // Join with the lower neighbor when adjacent
                wr_addr = ip_reg;
                we_link = 1'b1;
                if (lo_join)
                begin
                    wr_size = SZ_W'(rd_size_q + nsize_reg);
                    wr_link = nlink_reg;
                    we_size = 1'b1;
                end
                else
                begin
                    wr_link = ins_bp_reg;
                end
                rover_next    = ip_reg;
                res_ok_next   = 1'b1;
                res_addr_next = '0;
            end
            nfba_pkg::DP_FAIL:
            begin
                res_ok_next   = 1'b0;
                res_addr_next = '0;
            end
            nfba_pkg::DP_EMIT:
            begin
                granted_next = res_ok_reg;
                addr_next    = res_addr_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Memories: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we_link)
        begin
            link_mem[wr_addr] <= wr_link;
        end
        if (we_size)
        begin
            size_mem[wr_addr] <= wr_size;
        end
        rd_link_q <= link_mem[rd_addr];
        rd_size_q <= size_mem[rd_addr];
    end

    // Allocator state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            rover_reg       <= '0;
            bp_reg          <= BP_W'(1);
            grow_min_reg    <= nfba_pkg::GROW_MIN_RST;
            arena_limit_reg <= nfba_pkg::ARENA_LIMIT_RST;
        end
        else
        begin
            started_reg <= started_next;
            rover_reg   <= rover_next;
            bp_reg      <= bp_next;
            if (cfg_we && (cfg_index == nfba_pkg::CFG_GROW_MIN))
            begin
                grow_min_reg <= cfg_data[nfba_pkg::GROW_W-1:0];
            end
            if (cfg_we && (cfg_index == nfba_pkg::CFG_ARENA_LIMIT))
            begin
                arena_limit_reg <= cfg_data[nfba_pkg::LIMIT_W-1:0];
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        units_reg    <= units_next;
        fa_reg       <= fa_next;
        p_reg        <= p_next;
        prev_reg     <= prev_next;
        q_reg        <= q_next;
        steps_reg    <= steps_next;
        ip_reg       <= ip_next;
        isteps_reg   <= isteps_next;
        ins_bp_reg   <= ins_bp_next;
        nx_reg       <= nx_next;
        szbp_reg     <= szbp_next;
        nsize_reg    <= nsize_next;
        nlink_reg    <= nlink_next;
        res_ok_reg   <= res_ok_next;
        res_addr_reg <= res_addr_next;
        granted_reg  <= granted_next;
        addr_reg     <= addr_next;
    end

    assign granted = granted_reg;
    assign addr    = addr_reg;

endmodule

### hdl/next_fit_block_allocator.sv
// Flow: one transaction at a time; in_ready returns in the cycle after the result is handed
//   over. An allocate fetches and then checks each list block in turn, carves a tail when the
//   fit is not exact, and may grow the arena and insert the grown block; a free walks the list;
//   an ignored free skips the walk. A result still waiting for out_ready delays the hand-over
//   until it is taken.
// Reset: asynchronous, active low; clears rover and started flag, sets break pointer to one and config to reset values.
`timescale 1ns / 1ps

module next_fit_block_allocator #(
    parameter int HEAP_UNITS = nfba_pkg::HEAP_UNITS_DEF,
    parameter int UNIT_BYTES = nfba_pkg::UNIT_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [nfba_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [nfba_pkg::BYTES_W-1:0]  req_bytes,
    input  logic [nfba_pkg::ADDR_W-1:0]   free_addr,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          granted,
    output logic [nfba_pkg::ADDR_W-1:0]   addr
);

    nfba_pkg::dp_cmd_t  cmd;
    nfba_pkg::dp_stat_t st;

    // Sequencer
    nfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    // Memories and arithmetic
    nfba_dp #(
        .HEAP_UNITS (HEAP_UNITS),
        .UNIT_BYTES (UNIT_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .req_bytes (req_bytes),
        .free_addr (free_addr),
        .granted   (granted),
        .addr      (addr),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

### hdl/nfba_chk.sv
// Port-level checker for the next-fit block allocator, bound to the top level.
// Depends on nfba_pkg and next_fit_block_allocator.
`timescale 1ns / 1ps

module nfba_chk (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        granted,
    input logic [nfba_pkg::ADDR_W-1:0] addr
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(addr))
        else $error("result changed while stalled");

    // Drop ready after a transaction is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    // Failed results carry address zero
    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !granted |-> addr == '0)
        else $error("failed result with nonzero address");

endmodule

bind next_fit_block_allocator nfba_chk u_nfba_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .granted   (granted),
    .addr      (addr)
);

### tb/tb_next_fit_block_allocator.sv
// Testbench for next_fit_block_allocator: drives allocate and free transactions, predicts
// grants and addresses with its own free-list model, and checks every result in order.
// Depends on nfba_pkg and the allocator RTL.
`timescale 1ns / 1ps

module tb_next_fit_block_allocator;

    localparam int unsigned ARENA = 4096;
    localparam int unsigned UNIT_B = 16;
    localparam int unsigned STEP_CAP = 2 * ARENA + 8;
    localparam longint CYCLE_LIMIT = 8000000;

    typedef struct {
        logic                          op;
        logic [nfba_pkg::BYTES_W-1:0]  bytes;
        logic [nfba_pkg::ADDR_W-1:0]   fa;
    } request_t;

    typedef struct {
        logic                          ok;
        logic [nfba_pkg::ADDR_W-1:0]   a;
    } grant_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic                          cfg_index;
    logic [nfba_pkg::CFG_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic                          op;
    logic [nfba_pkg::BYTES_W-1:0]  req_bytes;
    logic [nfba_pkg::ADDR_W-1:0]   free_addr;
    logic                          out_valid;
    logic                          out_ready;
    logic                          granted;
    logic [nfba_pkg::ADDR_W-1:0]   addr;

    request_t     pending_reqs[$];
    grant_t       expected_grants[$];
    int unsigned  live_blocks[$];
    int           errors = 0;
    longint       cycles = 0;
    int           send_gap = 0;
    int           hold_gap = 0;

    // Free-list model state
    int unsigned  lnk[ARENA];
    int unsigned  blk_size[ARENA];
    int unsigned  rov;
    bit           list_up;
    int unsigned  brk;
    int unsigned  g_min;
    int unsigned  a_lim;

    next_fit_block_allocator uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .op(op),
        .req_bytes(req_bytes), .free_addr(free_addr), .out_valid(out_valid),
        .out_ready(out_ready), .granted(granted), .addr(addr)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Link a block into the address-ordered list and merge with neighbors
    function automatic bit insert_free_block(int unsigned bp);
        int unsigned p;
        int unsigned nx;
        int unsigned steps;
        p = rov;
        steps = 0;
        forever
        begin
            nx = lnk[p % ARENA];
            if (bp > p && bp < nx)
                break;
            if (p >= nx && (bp > p || bp < nx))
                break;
            steps++;
            if (steps > STEP_CAP)
                return 1'b0;
            p = nx;
        end
        nx = lnk[p % ARENA];
        if (bp + blk_size[bp % ARENA] == nx)
        begin
            blk_size[bp % ARENA] += blk_size[nx % ARENA];
            lnk[bp % ARENA] = lnk[nx % ARENA];
        end
        else
            lnk[bp % ARENA] = nx;
        if (p + blk_size[p % ARENA] == bp)
        begin
            blk_size[p % ARENA] += blk_size[bp % ARENA];
            lnk[p % ARENA] = lnk[bp % ARENA];
        end
        else
            lnk[p % ARENA] = bp;
        rov = p;
        return 1'b1;
    endfunction

    function automatic bit extend_arena(int unsigned units);
        int unsigned lim;
        int unsigned nu;
        int unsigned bp;
        lim = (a_lim < ARENA) ? a_lim : ARENA;
        nu = (units < g_min) ? g_min : units;
        bp = brk;
        if (bp + nu > lim)
            return 1'b0;
        blk_size[bp % ARENA] = nu;
        brk = bp + nu;
        return insert_free_block(bp);
    endfunction

    // Next-fit search from the rover; carve the tail of a larger block
    function automatic bit take_units(int unsigned bytes, output int unsigned data_unit);
        int unsigned units;
        int unsigned prv;
        int unsigned p;
        int unsigned q;
        units = (bytes + UNIT_B - 1) / UNIT_B + 1;
        prv = rov;
        p = lnk[prv % ARENA];
        data_unit = 0;
        for (int unsigned s = 0; s <= STEP_CAP; s++)
        begin
            if (blk_size[p % ARENA] >= units)
            begin
                q = p;
                if (blk_size[p % ARENA] == units)
                    lnk[prv % ARENA] = lnk[p % ARENA];
                else
                begin
                    blk_size[p % ARENA] -= units;
                    q = (p + blk_size[p % ARENA]) % ARENA;
                    blk_size[q] = units;
                end
                rov = prv;
                data_unit = (q + 1) & 12'hFFF;
                return 1'b1;
            end
            if (p == rov)
            begin
                if (!extend_arena(units))
                    return 1'b0;
                p = rov;
            end
            prv = p;
            p = lnk[p % ARENA];
        end
        return 1'b0;
    endfunction

    function automatic grant_t predict_grant(request_t r);
        grant_t g;
        int unsigned a;
        if (!list_up)
        begin
            lnk[0] = 0;
            blk_size[0] = 0;
            rov = 0;
            list_up = 1'b1;
        end
        a = 0;
        if (r.op == nfba_pkg::OP_ALLOC)
        begin
            g.ok = take_units(r.bytes, a);
            if (!g.ok)
                a = 0;
        end
        else if (r.fa < 2 || r.fa - 1 >= brk)
            g.ok = 1'b0;
        else
            g.ok = insert_free_block(r.fa - 1);
        g.a = a[nfba_pkg::ADDR_W-1:0];
        return g;
    endfunction

    // Queue one transaction with its predicted grant; track live blocks
    task automatic issue(logic o, int unsigned bytes, int unsigned fa);
        request_t r;
        grant_t g;
        r.op = o;
        r.bytes = bytes[nfba_pkg::BYTES_W-1:0];
        r.fa = fa[nfba_pkg::ADDR_W-1:0];
        g = predict_grant(r);
        if (o == nfba_pkg::OP_ALLOC && g.ok && g.a != 0)
            live_blocks.push_back(g.a);
        pending_reqs.push_back(r);
        expected_grants.push_back(g);
    endtask

    task automatic release_live(int unsigned k);
        int unsigned fa;
        fa = live_blocks[k];
        live_blocks.delete(k);
        issue(nfba_pkg::OP_FREE, $urandom, fa);
    endtask

    task automatic random_item();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (live_blocks.size() > 0 && r < 45)
            release_live($urandom_range(0, live_blocks.size() - 1));
        else if (r >= 95)
        begin
            // ignored free: at or below the sentinel or past the break
            if (brk < ARENA - 1 && $urandom_range(0, 1))
                issue(nfba_pkg::OP_FREE, $urandom, $urandom_range(brk + 1, ARENA - 1));
            else
                issue(nfba_pkg::OP_FREE, $urandom, $urandom_range(0, 1));
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                issue(nfba_pkg::OP_ALLOC, $urandom_range(0, 600), $urandom);
            else if (r < 95)
                issue(nfba_pkg::OP_ALLOC, $urandom_range(0, 8000), $urandom);
            else
                issue(nfba_pkg::OP_ALLOC, $urandom_range(0, 65535), $urandom);
        end
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[nfba_pkg::CFG_W-1:0];
        if (idx == nfba_pkg::CFG_GROW_MIN)
            g_min = value & 12'hFFF;
        else
            a_lim = value & 13'h1FFF;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_valid || expected_grants.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_phase(int unsigned gm, int unsigned lim, int n);
        wait_drained();
        write_reg(nfba_pkg::CFG_GROW_MIN, gm);
        write_reg(nfba_pkg::CFG_ARENA_LIMIT, lim);
        repeat (n) random_item();
    endtask

    // Input driver: hold until accepted, then idle for a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= nfba_pkg::OP_ALLOC;
            req_bytes <= '0;
            free_addr <= '0;
            send_gap = 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                request_t r;
                r = pending_reqs.pop_front();
                op <= r.op;
                req_bytes <= r.bytes;
                free_addr <= r.fa;
                in_valid <= 1'b1;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: send_gap = 0;
                    5, 6, 7: send_gap = $urandom_range(1, 3);
                    8: send_gap = $urandom_range(4, 10);
                    default: send_gap = $urandom_range(10, 40);
                endcase
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor: compare against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    $display("%0t: unexpected result granted=%0b addr=%0d", $time, granted, addr);
                    errors++;
                end
                else
                begin
                    grant_t g;
                    g = expected_grants.pop_front();
                    if (granted !== g.ok)
                    begin
                        $display("%0t: granted expected %0b actual %0b", $time, g.ok, granted);
                        errors++;
                    end
                    if (addr !== g.a)
                    begin
                        $display("%0t: addr expected %0d actual %0d", $time, g.a, addr);
                        errors++;
                    end
                end
            end
            if (hold_gap > 0)
            begin
                hold_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 31))
                    0, 1, 2, 3: out_ready <= 1'b0;
                    4: out_ready <= ($urandom_range(0, 7) == 0);
                    5:
                    begin
                        // long stall
                        hold_gap = $urandom_range(8, 40);
                        out_ready <= 1'b0;
                    end
                    default: out_ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int unsigned a1;
        int unsigned a2;
        int unsigned a3;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = nfba_pkg::CFG_GROW_MIN;
        cfg_data = '0;
        rov = 0;
        list_up = 1'b0;
        brk = 1;
        g_min = nfba_pkg::GROW_MIN_RST;
        a_lim = nfba_pkg::ARENA_LIMIT_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first use by a free, size extremes, exact fit, coalescing
        issue(nfba_pkg::OP_FREE, 0, 0);
        issue(nfba_pkg::OP_FREE, 16'hFFFF, 1);
        issue(nfba_pkg::OP_ALLOC, 0, 12'hFFF);
        issue(nfba_pkg::OP_ALLOC, 1, 0);
        issue(nfba_pkg::OP_ALLOC, 16, 0);
        issue(nfba_pkg::OP_ALLOC, 17, 0);
        issue(nfba_pkg::OP_ALLOC, 65535, 0);
        issue(nfba_pkg::OP_FREE, 0, 4095);
        issue(nfba_pkg::OP_ALLOC, 100, 0);
        a1 = live_blocks[live_blocks.size() - 1];
        release_live(live_blocks.size() - 1);
        issue(nfba_pkg::OP_ALLOC, 100, 0);
        issue(nfba_pkg::OP_ALLOC, 200, 0);
        issue(nfba_pkg::OP_ALLOC, 300, 0);
        issue(nfba_pkg::OP_ALLOC, 400, 0);
        a1 = live_blocks.size();
        release_live(a1 - 3);
        release_live(a1 - 3);
        release_live(a1 - 4);
        issue(nfba_pkg::OP_ALLOC, 16000, 0);
        issue(nfba_pkg::OP_ALLOC, 50000, 0);
        while (live_blocks.size() > 0)
            release_live(0);
        repeat (140) random_item();

        run_phase(1, 4096, 100);
        run_phase(0, 0, 30);
        run_phase(4095, 4096, 80);
        run_phase(7, 1, 60);
        a2 = $urandom_range(1, 4095);
        a3 = $urandom_range(1, 4096);
        run_phase(a2, a3, 100);

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
